// ----- rtl/ptbg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the palette tint blend block.
// No dependencies; ptbg_tint_stage, the top level and the testbench import this package.
package ptbg_pkg;

  localparam int COLOR_W = 8;
  localparam int TABLE_DEPTH = 2 ** COLOR_W;
  localparam int TINT_REGS = 4;
  localparam int TINT_IDX_W = $clog2(TINT_REGS);
  localparam int TINT_STAGES_DEF = 4;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] pct;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } tint_t;

  // For a table write, red carries the entry index and green the value.
  typedef struct packed {
    logic               blend;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pix_t;

endpackage

// ----- rtl/ptbg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ptbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ptbg_tint_stage.sv -----
`timescale 1ns / 1ps
// One registered tint stage: each channel moves toward the target color.
// Depends on ptbg_pkg for the pixel and tint types.
module ptbg_tint_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           in_valid,
  input  ptbg_pkg::pix_t in_pix,
  input  ptbg_pkg::tint_t tint,
  output logic           out_valid,
  output ptbg_pkg::pix_t out_pix
);
  import ptbg_pkg::*;

  function automatic logic [COLOR_W-1:0] tint_ch(input logic [COLOR_W-1:0] c,
                                                 input logic [COLOR_W-1:0] d,
                                                 input logic [COLOR_W-1:0] p);
    logic signed [COLOR_W:0]     diff;
    logic signed [2*COLOR_W+1:0] prod;
    logic signed [COLOR_W+1:0]   delta;
    logic [COLOR_W+1:0]          sum;
    diff  = $signed({1'b0, d}) - $signed({1'b0, c});
    prod  = $signed({1'b0, p}) * diff;
    delta = prod[2*COLOR_W+1:COLOR_W];
    sum   = {2'b00, c} + unsigned'(delta);
    return sum[COLOR_W-1:0];
  endfunction

  pix_t pix_next;

  always_comb begin
    pix_next = in_pix;
    if (in_pix.blend) begin
      pix_next.red   = tint_ch(in_pix.red, tint.red, tint.pct);
      pix_next.green = tint_ch(in_pix.green, tint.green, tint.pct);
      pix_next.blue  = tint_ch(in_pix.blue, tint.blue, tint.pct);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
    if (load) begin
      out_pix <= pix_next;
    end
  end

endmodule

// ----- rtl/palette_tint_blend_gamma.sv -----
`timescale 1ns / 1ps
// Top level of the palette tint blend with gamma lookup.
// Depends on ptbg_pkg, ptbg_tint_stage and ptbg_ram.
//
// Each input beat either writes one gamma table entry or blends one palette
// color. A blend beat runs through TINT_STAGES tint stages, one register
// stage each, then a gamma read stage and an output register.
// A new beat is accepted every cycle while in_stall is low; throughput is
// one color per cycle while the receiver does not stall.
// Table writes travel down the same pipeline and update the table at the
// gamma read stage, so every blend sees exactly the writes accepted before
// it. A table write produces no output beat.
// The three channels read three copies of the table, each one RAM port.
// Tint registers are written through the configuration channel, which is
// always ready. Reset clears the tint registers and the per-entry valid
// bits; an entry never written reads as its own index, so the table is the
// identity right after reset with no clearing pass.
// When the receiver stalls, the output beat holds; stages behind it keep
// filling empty slots and in_stall rises only once the pipeline is full.
module palette_tint_blend_gamma #(
  parameter int TINT_STAGES = ptbg_pkg::TINT_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic [ptbg_pkg::COLOR_W-1:0]     red_in,
  input  logic [ptbg_pkg::COLOR_W-1:0]     green_in,
  input  logic [ptbg_pkg::COLOR_W-1:0]     blue_in,
  input  logic [ptbg_pkg::COLOR_W-1:0]     table_index,
  input  logic [ptbg_pkg::COLOR_W-1:0]     table_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ptbg_pkg::COLOR_W-1:0]     red_out,
  output logic [ptbg_pkg::COLOR_W-1:0]     green_out,
  output logic [ptbg_pkg::COLOR_W-1:0]     blue_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptbg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptbg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ptbg_pkg::*;

  tint_t tint_reg [TINT_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TINT_REGS; i++) begin
        tint_reg[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < CFG_INDEX_W'(TINT_REGS)) begin
      tint_reg[cfg_index[TINT_IDX_W-1:0]] <= tint_t'(cfg_data);
    end
  end

  pix_t                   in_pix;
  pix_t                   stage_pix   [TINT_STAGES];
  tint_t                  stage_tint  [TINT_STAGES];
  logic [TINT_STAGES-1:0] stage_valid;
  logic [TINT_STAGES-1:0] stage_ready;
  logic                   gamma_ready;
  logic                   out_ready;

  always_comb begin
    in_pix.blend = (operation == OP_BLEND);
    in_pix.red   = in_pix.blend ? red_in : table_index;
    in_pix.green = in_pix.blend ? green_in : table_value;
    in_pix.blue  = blue_in;
  end

  assign in_stall = !stage_ready[0];

  for (genvar s = 0; s < TINT_STAGES; s++) begin : g_stage
    if (s < TINT_REGS) begin : g_reg
      assign stage_tint[s] = tint_reg[s];
    end else begin : g_pass
      assign stage_tint[s] = '0;
    end

    if (s == TINT_STAGES - 1) begin : g_last
      assign stage_ready[s] = !stage_valid[s] || gamma_ready;
    end else begin : g_mid
      assign stage_ready[s] = !stage_valid[s] || stage_ready[s+1];
    end

    if (s == 0) begin : g_first
      ptbg_tint_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .load      (stage_ready[s]),
        .in_valid  (in_valid),
        .in_pix    (in_pix),
        .tint      (stage_tint[s]),
        .out_valid (stage_valid[s]),
        .out_pix   (stage_pix[s])
      );
    end else begin : g_next
      ptbg_tint_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .load      (stage_ready[s]),
        .in_valid  (stage_valid[s-1]),
        .in_pix    (stage_pix[s-1]),
        .tint      (stage_tint[s]),
        .out_valid (stage_valid[s]),
        .out_pix   (stage_pix[s])
      );
    end
  end

  // Gamma stage: table writes land here, blends read the three table copies.
  pix_t                   last_pix;
  logic                   last_valid;
  logic                   table_we;
  logic                   table_re;
  logic [TABLE_DEPTH-1:0] gamma_valid;
  logic                   gamma_stage_valid;
  logic [COLOR_W-1:0]     addr_red;
  logic [COLOR_W-1:0]     addr_green;
  logic [COLOR_W-1:0]     addr_blue;
  logic                   hit_red;
  logic                   hit_green;
  logic                   hit_blue;
  logic [COLOR_W-1:0]     q_red;
  logic [COLOR_W-1:0]     q_green;
  logic [COLOR_W-1:0]     q_blue;

  assign last_pix    = stage_pix[TINT_STAGES-1];
  assign last_valid  = stage_valid[TINT_STAGES-1];
  assign out_ready   = !out_valid || !out_stall;
  assign gamma_ready = !gamma_stage_valid || out_ready;
  assign table_we    = gamma_ready && last_valid && !last_pix.blend;
  assign table_re    = gamma_ready && last_valid && last_pix.blend;

  ptbg_ram #(.WIDTH(COLOR_W), .DEPTH(TABLE_DEPTH)) u_ram_red (
    .clk   (clk),
    .we    (table_we),
    .waddr (last_pix.red),
    .wdata (last_pix.green),
    .re    (table_re),
    .raddr (last_pix.red),
    .rdata (q_red)
  );

  ptbg_ram #(.WIDTH(COLOR_W), .DEPTH(TABLE_DEPTH)) u_ram_green (
    .clk   (clk),
    .we    (table_we),
    .waddr (last_pix.red),
    .wdata (last_pix.green),
    .re    (table_re),
    .raddr (last_pix.green),
    .rdata (q_green)
  );

  ptbg_ram #(.WIDTH(COLOR_W), .DEPTH(TABLE_DEPTH)) u_ram_blue (
    .clk   (clk),
    .we    (table_we),
    .waddr (last_pix.red),
    .wdata (last_pix.green),
    .re    (table_re),
    .raddr (last_pix.blue),
    .rdata (q_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_valid       <= '0;
      gamma_stage_valid <= 1'b0;
    end else begin
      if (table_we) begin
        gamma_valid[last_pix.red] <= 1'b1;
      end
      if (gamma_ready) begin
        gamma_stage_valid <= last_valid && last_pix.blend;
      end
    end
    if (table_re) begin
      addr_red   <= last_pix.red;
      addr_green <= last_pix.green;
      addr_blue  <= last_pix.blue;
      hit_red    <= gamma_valid[last_pix.red];
      hit_green  <= gamma_valid[last_pix.green];
      hit_blue   <= gamma_valid[last_pix.blue];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= gamma_stage_valid;
    end
    if (out_ready && gamma_stage_valid) begin
      red_out   <= hit_red ? q_red : addr_red;
      green_out <= hit_green ? q_green : addr_green;
      blue_out  <= hit_blue ? q_blue : addr_blue;
    end
  end

endmodule

// ----- tb/palette_tint_blend_gamma_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for palette_tint_blend_gamma: directed and random
// palette beats, random sender bursts and receiver stalls, in-order checking.
// Depends on ptbg_pkg and the RTL of the block; reads no files.
module palette_tint_blend_gamma_tb;
  import ptbg_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_TINT_ZERO = 0;
  localparam logic [CFG_INDEX_W-1:0] REG_TINT_ONE = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TINT_TWO = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TINT_THREE = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = TINT_REGS;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX = 255;
  localparam int PIPE_SLACK = TINT_STAGES_DEF + 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  class palette_scoreboard;
    tint_t tints[TINT_REGS];
    logic [COLOR_W-1:0] gamma_lut[TABLE_DEPTH];
    rgb_t expected_colors[$];
    int failures;

    function new();
      int i;
      failures = 0;
      for (i = 0; i < TINT_REGS; i++) tints[i] = '0;
      for (i = 0; i < TABLE_DEPTH; i++) gamma_lut[i] = COLOR_W'(i);
    endfunction

    function void set_tint(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index < TINT_REGS) begin
        tints[index] = tint_t'(data);
      end
    endfunction

    function logic [COLOR_W-1:0] tint_channel(logic [COLOR_W-1:0] c, logic [COLOR_W-1:0] dest,
                                              logic [COLOR_W-1:0] pct);
      int prod;
      prod = int'(pct) * (int'(dest) - int'(c));
      return COLOR_W'(int'(c) + (prod >>> 8));
    endfunction

    function void note_entry(logic op, rgb_t color, logic [COLOR_W-1:0] index,
                             logic [COLOR_W-1:0] value);
      rgb_t c;
      int s;
      if (op == OP_WRITE) begin
        gamma_lut[index] = value;
      end else begin
        c = color;
        for (s = 0; s < TINT_STAGES_DEF; s++) begin
          if (s < TINT_REGS) begin
            c.red = tint_channel(c.red, tints[s].red, tints[s].pct);
            c.green = tint_channel(c.green, tints[s].green, tints[s].pct);
            c.blue = tint_channel(c.blue, tints[s].blue, tints[s].pct);
          end
        end
        expected_colors.push_back({gamma_lut[c.red], gamma_lut[c.green], gamma_lut[c.blue]});
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (expected_colors.size() == 0) begin
        report($sformatf("Unexpected output beat r=%0d g=%0d b=%0d.",
                         got.red, got.green, got.blue));
      end else begin
        want = expected_colors.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          report($sformatf("Color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d.",
                           want.red, want.green, want.blue, got.red, got.green, got.blue));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;
  logic [COLOR_W-1:0] table_index;
  logic [COLOR_W-1:0] table_value;
  logic out_valid;
  logic out_stall;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  palette_scoreboard sb;
  int stall_mode;
  int stall_left;

  palette_tint_blend_gamma dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .table_index(table_index),
    .table_value(table_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL palette_tint_blend_gamma");
    $finish;
  end

  // The receiver switches between free-running, light, heavy and periodic stalls.
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 3) != 0);
        default: out_stall = ((stall_left % 6) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_color({red_out, green_out, blue_out});
    end
  end

  function automatic logic [COLOR_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_tint();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  task automatic send_entry(logic op, rgb_t color, logic [COLOR_W-1:0] index,
                            logic [COLOR_W-1:0] value);
    @(negedge clk);
    operation = op;
    red_in = color.red;
    green_in = color.green;
    blue_in = color.blue;
    table_index = index;
    table_value = value;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_entry(op, color, index, value);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index = index;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_tint(index, data);
  endtask

  // Table writes leave no output beat, so wait out the pipeline after the last color.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic send_random();
    logic op;
    op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_BLEND;
    send_entry(op, {rand_byte(), rand_byte(), rand_byte()}, rand_byte(), rand_byte());
  endtask

  task automatic run_random(int count);
    int burst_left;
    int k;
    burst_left = $urandom_range(1, 40);
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_random();
    end
  endtask

  initial begin
    int phase;
    int r;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_BLEND;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    table_index = '0;
    table_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_entry(OP_BLEND, {8'h00, 8'h00, 8'h00}, 8'hff, 8'hff);
    send_entry(OP_BLEND, {8'hff, 8'hff, 8'hff}, 8'h00, 8'h00);
    send_entry(OP_BLEND, {8'h00, 8'hff, 8'h55}, 8'hff, 8'h00);
    send_entry(OP_WRITE, {8'hff, 8'hff, 8'hff}, 8'h00, 8'hff);
    send_entry(OP_WRITE, {8'h00, 8'h00, 8'h00}, 8'hff, 8'h00);
    send_entry(OP_BLEND, {8'h00, 8'hff, 8'h80}, 8'h00, 8'h00);
    send_entry(OP_WRITE, {8'h12, 8'h34, 8'h56}, 8'h80, 8'h80);

    settle();
    write_reg(REG_TINT_ZERO, 32'hffff_ffff);
    write_reg(REG_TINT_ONE, 32'h8000_0000);
    write_reg(REG_TINT_TWO, 32'h0100_ff80);
    write_reg(REG_TINT_THREE, 32'h00aa_550f);
    write_reg(REG_FIRST_UNUSED, 32'hffff_ffff);
    write_reg(REG_LAST_INDEX, 32'h0000_0000);
    settle();

    send_entry(OP_BLEND, {8'h00, 8'h00, 8'h00}, 8'hff, 8'hff);
    send_entry(OP_BLEND, {8'hff, 8'hff, 8'hff}, 8'hff, 8'hff);
    send_entry(OP_BLEND, {8'h00, 8'hff, 8'h00}, 8'h00, 8'hff);
    send_entry(OP_BLEND, {8'hff, 8'h00, 8'hff}, 8'hff, 8'h00);
    send_entry(OP_WRITE, {8'h00, 8'h00, 8'h00}, 8'h7f, 8'h01);
    send_entry(OP_BLEND, {8'h80, 8'h7f, 8'h01}, 8'h55, 8'haa);
    send_entry(OP_BLEND, {8'h7f, 8'h7f, 8'h7f}, 8'h00, 8'h00);

    for (phase = 0; phase < 7; phase++) begin
      settle();
      for (r = 0; r < TINT_REGS; r++) begin
        case (phase)
          0: write_reg(CFG_INDEX_W'(r), {8'hff, rand_byte(), rand_byte(), rand_byte()});
          1: write_reg(CFG_INDEX_W'(r), {8'h00, rand_byte(), rand_byte(), rand_byte()});
          2: write_reg(CFG_INDEX_W'(r), (r % 2 == 0) ? 32'hff00_0000 : 32'hffff_ffff);
          default: write_reg(CFG_INDEX_W'(r), rand_tint());
        endcase
      end
      write_reg(CFG_INDEX_W'($urandom_range(TINT_REGS, 255)), rand_tint());
      settle();
      if (phase == 3) begin
        run_random(50);
        settle();
        run_random(50);
      end else begin
        run_random(100);
      end
    end

    settle();
    if (sb.failures == 0 && sb.expected_colors.size() == 0) begin
      $display("PASS palette_tint_blend_gamma");
    end else begin
      $display("FAIL palette_tint_blend_gamma");
    end
    $finish;
  end

endmodule
